@@ sv/clamped_edge_fir_convolution_assert.svh @@
// Assertion macros for the clamped edge FIR convolution block.
// Used by files that include this header; expects signals clock and reset.
`ifndef CLAMPED_EDGE_FIR_CONVOLUTION_ASSERT_SVH
`define CLAMPED_EDGE_FIR_CONVOLUTION_ASSERT_SVH
`ifndef SYNTH
`define CEFC_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("cefc assertion failed");
`define CEFC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("cefc assertion failed");
`else
`define CEFC_ASSERT_NOW(lbl, ante, cons)
`define CEFC_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/cefc_pkg.sv @@
// Shared types and constants for the clamped edge FIR convolution block.
// No dependencies.
package cefc_pkg;

   localparam int NUM_COEF        = 7;
   localparam int COEF_SIDE       = 3;
   localparam int COEF_WIDTH      = 16;
   localparam int COEF_FRAC       = 15;
   localparam int SUM_GROWTH      = 3;
   localparam int HW_WIDTH        = 2;
   localparam int TAP_CHOICES     = 2 ** HW_WIDTH;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_HALF_WIDTH = 3'd0;

   localparam logic signed [COEF_WIDTH-1:0] COEF_CENTRE_RESET = 16'sd32767;

   typedef logic [HW_WIDTH-1:0] h_type;

   typedef struct packed {
      logic push;
      logic fill;
   } win_ctl_type;

endpackage

@@ sv/cefc_win_cell.sv @@
// One window cell: holds a sample and, on every push, takes its neighbor's or, with fill set, the fill sample.
// Depends on cefc_pkg.
module cefc_win_cell #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                           clock,
   input  cefc_pkg::win_ctl_type          ctl,
   input  logic signed [SAMPLE_WIDTH-1:0] fill_data,
   input  logic signed [SAMPLE_WIDTH-1:0] shift_data,
   output logic signed [SAMPLE_WIDTH-1:0] q
);

   logic signed [SAMPLE_WIDTH-1:0] data_ff;
   logic signed [SAMPLE_WIDTH-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctl.push) begin
         data_in = ctl.fill ? fill_data : shift_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

@@ sv/cefc_mac_cell.sv @@
// One tap cell: picks the window sample for the active half width and
// registers its product with the coefficient. Depends on cefc_pkg.
module cefc_mac_cell #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                                 clock,
   input  logic                                                 en,
   input  cefc_pkg::h_type                                      h,
   input  logic signed [SAMPLE_WIDTH-1:0]                       cand [cefc_pkg::TAP_CHOICES],
   input  logic signed [cefc_pkg::COEF_WIDTH-1:0]               coef,
   output logic signed [SAMPLE_WIDTH+cefc_pkg::COEF_WIDTH-1:0]  prod
);

   localparam int PW = SAMPLE_WIDTH + cefc_pkg::COEF_WIDTH;

   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;

   always_comb begin
      prod_in = prod_ff;
      if (en) begin
         prod_in = cand[h] * coef;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ sv/cefc_round_sat.sv @@
// Output stage: adds the tap products, rounds Q1.15 to nearest and
// saturates to the sample width. Depends on cefc_pkg.
module cefc_round_sat #(
   parameter int SAMPLE_WIDTH = 16
) (
   input  logic                                                clock,
   input  logic                                                en,
   input  logic signed [SAMPLE_WIDTH+cefc_pkg::COEF_WIDTH-1:0] prods [cefc_pkg::NUM_COEF],
   output logic signed [SAMPLE_WIDTH-1:0]                      filtered
);

   localparam int PW = SAMPLE_WIDTH + cefc_pkg::COEF_WIDTH;
   localparam int AW = PW + cefc_pkg::SUM_GROWTH + 1;
   localparam logic signed [AW-1:0] HALF = AW'(1) <<< (cefc_pkg::COEF_FRAC - 1);
   localparam logic signed [AW-1:0] MAXV = {{(AW-SAMPLE_WIDTH+1){1'b0}},
                                            {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [AW-1:0] MINV = {{(AW-SAMPLE_WIDTH+1){1'b1}},
                                            {(SAMPLE_WIDTH-1){1'b0}}};

   logic signed [AW-1:0]           acc;
   logic signed [AW-1:0]           scaled;
   logic signed [SAMPLE_WIDTH-1:0] filtered_ff;
   logic signed [SAMPLE_WIDTH-1:0] filtered_in;

   always_comb begin
      acc = HALF;
      for (int k = 0; k < cefc_pkg::NUM_COEF; k++) begin
         acc = acc + AW'(prods[k]);
      end
      scaled = acc >>> cefc_pkg::COEF_FRAC;
      filtered_in = filtered_ff;
      if (en) begin
         if (scaled > MAXV) begin
            filtered_in = MAXV[SAMPLE_WIDTH-1:0];
         end else if (scaled < MINV) begin
            filtered_in = MINV[SAMPLE_WIDTH-1:0];
         end else begin
            filtered_in = scaled[SAMPLE_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      filtered_ff <= filtered_in;
   end

   assign filtered = filtered_ff;

endmodule

@@ sv/clamped_edge_fir_convolution.sv @@
// Centered FIR with edge replication over a chain of window cells, seven tap
// cells and a round/saturate output register. One item per cycle while
// req_ready is high; each item passes through the window, product and
// output registers in that order. An item marked end_of_curve with half
// width h is followed by h flush steps in which req_ready is low and the
// window cells shift the last sample again. Depends on cefc_pkg,
// cefc_win_cell, cefc_mac_cell, cefc_round_sat and the assert header.
`include "clamped_edge_fir_convolution_assert.svh"

module clamped_edge_fir_convolution #(
   parameter int MAX_HALF_WIDTH = 3,
   parameter int SAMPLE_WIDTH   = 16
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]             req_sample,
   input  logic                                       req_end_of_curve,
   output logic                                       rsp_valid,
   input  logic                                       rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]             rsp_filtered,
   output logic                                       rsp_final_out,
   input  logic                                       csr_write_enable,
   input  logic [cefc_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [cefc_pkg::CSR_DATA_WIDTH-1:0]        csr_write_data
);

   localparam int W    = 2 * MAX_HALF_WIDTH + 1;
   localparam int HMAX = (MAX_HALF_WIDTH < cefc_pkg::COEF_SIDE) ? MAX_HALF_WIDTH
                                                                : cefc_pkg::COEF_SIDE;
   localparam int PW   = SAMPLE_WIDTH + cefc_pkg::COEF_WIDTH;

   cefc_pkg::h_type                         half_width_ff;
   logic signed [cefc_pkg::COEF_WIDTH-1:0]  coef_ff [cefc_pkg::NUM_COEF];

   logic [1:0]      recv_ff, recv_in;
   logic            flush_ff, flush_in;
   logic [1:0]      left_ff, left_in;
   logic [1:0]      fl_n_ff, fl_n_in;
   cefc_pkg::h_type fl_h_ff, fl_h_in;
   logic            v0_ff, v0_in, fin0_ff, fin0_in;
   cefc_pkg::h_type h0_ff, h0_in;
   logic            v1_ff, v1_in, fin1_ff, fin1_in;
   logic            v2_ff, v2_in, fin2_ff, fin2_in;

   cefc_pkg::h_type       h_eff;
   cefc_pkg::win_ctl_type win_ctl;
   logic                  adv0, adv1, adv2;
   logic                  accept, step;
   logic [1:0]            fl_nk;
   logic                  emit0, final0;

   logic signed [SAMPLE_WIDTH-1:0] win [W];
   logic signed [SAMPLE_WIDTH-1:0] newest;
   logic signed [SAMPLE_WIDTH-1:0] cand [cefc_pkg::NUM_COEF][cefc_pkg::TAP_CHOICES];
   logic signed [PW-1:0]           prods [cefc_pkg::NUM_COEF];

   always_ff @(posedge clock) begin
      if (reset) begin
         half_width_ff <= '0;
         for (int k = 0; k < cefc_pkg::NUM_COEF; k++) begin
            coef_ff[k] <= (k == cefc_pkg::COEF_SIDE) ? cefc_pkg::COEF_CENTRE_RESET : '0;
         end
      end else if (csr_write_enable) begin
         unique case (csr_index)
            cefc_pkg::REG_HALF_WIDTH: begin
               half_width_ff <= csr_write_data[cefc_pkg::HW_WIDTH-1:0];
            end
            default: begin
               coef_ff[csr_index - 3'd1] <= csr_write_data;
            end
         endcase
      end
   end

   assign h_eff = (half_width_ff > cefc_pkg::HW_WIDTH'(HMAX)) ? cefc_pkg::HW_WIDTH'(HMAX)
                                                             : half_width_ff;

   assign adv2      = !v2_ff || rsp_ready;
   assign adv1      = !v1_ff || adv2;
   assign adv0      = !v0_ff || adv1;
   assign req_ready = !flush_ff && adv0;
   assign accept    = req_valid && req_ready;
   assign step      = flush_ff && adv0;
   assign fl_nk     = (fl_n_ff == 2'b11) ? fl_n_ff : fl_n_ff + 2'd1;

   assign win_ctl.push = accept || step;
   assign win_ctl.fill = accept && (recv_ff == 2'd0);
   assign newest       = flush_ff ? win[W-1] : req_sample;

   always_comb begin
      recv_in  = recv_ff;
      flush_in = flush_ff;
      left_in  = left_ff;
      fl_n_in  = fl_n_ff;
      fl_h_in  = fl_h_ff;
      emit0    = 1'b0;
      final0   = 1'b0;
      h0_in    = h0_ff;
      if (accept) begin
         emit0  = {1'b0, recv_ff} >= {1'b0, h_eff};
         final0 = req_end_of_curve && (h_eff == '0);
         h0_in  = h_eff;
         if (req_end_of_curve) begin
            recv_in  = 2'd0;
            flush_in = (h_eff != '0);
            left_in  = h_eff;
            fl_n_in  = recv_ff;
            fl_h_in  = h_eff;
         end else if (recv_ff != 2'b11) begin
            recv_in = recv_ff + 2'd1;
         end
      end else if (step) begin
         emit0   = fl_nk >= fl_h_ff;
         final0  = (left_ff == 2'd1);
         h0_in   = fl_h_ff;
         fl_n_in = fl_nk;
         left_in = left_ff - 2'd1;
         if (left_ff == 2'd1) begin
            flush_in = 1'b0;
         end
      end
      v0_in   = v0_ff;
      fin0_in = fin0_ff;
      if (adv0) begin
         v0_in   = win_ctl.push && emit0;
         fin0_in = final0;
      end
      v1_in   = v1_ff;
      fin1_in = fin1_ff;
      if (adv1) begin
         v1_in   = v0_ff;
         fin1_in = fin0_ff;
      end
      v2_in   = v2_ff;
      fin2_in = fin2_ff;
      if (adv2) begin
         v2_in   = v1_ff;
         fin2_in = fin1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         recv_ff  <= '0;
         flush_ff <= 1'b0;
         left_ff  <= '0;
         fl_n_ff  <= '0;
         fl_h_ff  <= '0;
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
      end else begin
         recv_ff  <= recv_in;
         flush_ff <= flush_in;
         left_ff  <= left_in;
         fl_n_ff  <= fl_n_in;
         fl_h_ff  <= fl_h_in;
         v0_ff    <= v0_in;
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      h0_ff   <= h0_in;
      fin0_ff <= fin0_in;
      fin1_ff <= fin1_in;
      fin2_ff <= fin2_in;
   end

   for (genvar k = 0; k < W; k++) begin : g_win
      logic signed [SAMPLE_WIDTH-1:0] nbr;
      if (k == W - 1) begin : g_top
         assign nbr = newest;
      end else begin : g_mid
         assign nbr = win[k+1];
      end
      cefc_win_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_cell (
         .clock      (clock),
         .ctl        (win_ctl),
         .fill_data  (req_sample),
         .shift_data (nbr),
         .q          (win[k])
      );
   end

   for (genvar c = 0; c < cefc_pkg::NUM_COEF; c++) begin : g_tap
      for (genvar hh = 0; hh < cefc_pkg::TAP_CHOICES; hh++) begin : g_sel
         if (hh <= HMAX && c >= cefc_pkg::COEF_SIDE - hh && c <= cefc_pkg::COEF_SIDE + hh)
         begin : g_on
            assign cand[c][hh] = win[W - 1 - cefc_pkg::COEF_SIDE - hh + c];
         end else begin : g_off
            assign cand[c][hh] = '0;
         end
      end
      cefc_mac_cell #(
         .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_mac (
         .clock (clock),
         .en    (adv1),
         .h     (h0_ff),
         .cand  (cand[c]),
         .coef  (coef_ff[c]),
         .prod  (prods[c])
      );
   end

   cefc_round_sat #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_round_sat (
      .clock    (clock),
      .en       (adv2),
      .prods    (prods),
      .filtered (rsp_filtered)
   );

   assign rsp_valid     = v2_ff;
   assign rsp_final_out = fin2_ff;

   `CEFC_ASSERT_NEXT(a_flush_start, accept && req_end_of_curve && h_eff != 2'd0, flush_ff)
   `CEFC_ASSERT_NEXT(a_flush_end, step && left_ff == 2'd1, !flush_ff && recv_ff == 2'd0)
   `CEFC_ASSERT_NEXT(a_recv_count, accept && !req_end_of_curve && recv_ff != 2'b11, recv_ff == $past(recv_ff) + 2'd1)

endmodule
